// ===== design/bitmap_priority_task_scheduler_assert.svh =====
// assertion macros for the bitmap priority task scheduler
// expects clk and rst_n in the scope of each use
`ifndef BITMAP_PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define BITMAP_PRIORITY_TASK_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define BPTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bpts_pkg.sv =====
// shared types, codes and defaults for the bitmap priority task scheduler
// no dependencies
package bpts_pkg;

    localparam int TASK_SLOTS_DEF  = 32;
    localparam int WAIT_QUEUES_DEF = 8;
    localparam int SLOT_FIELD_W    = 5;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 16;

    typedef enum logic [2:0] {
        ACT_CREATE,
        ACT_DELETE,
        ACT_START,
        ACT_STOP,
        ACT_PICK,
        ACT_BLOCK,
        ACT_WAKE,
        ACT_READ
    } action_t;

    typedef enum logic [1:0] {
        SS_FREE,
        SS_DORMANT,
        SS_READY,
        SS_BLOCKED
    } slot_state_t;

    typedef enum logic [1:0] {
        STS_OK,
        STS_WRONG,
        STS_EMPTY
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_CANCEL
    } fsm_t;

    typedef struct packed {
        action_t     action;
        logic [4:0]  task_slot;
        logic [2:0]  wait_queue;
    } cmd_t;

    // status in the low bits, cancel_notice on top
    typedef struct packed {
        logic        cancel_notice;
        slot_state_t slot_state;
        logic [4:0]  chosen_slot;
        status_t     status;
    } result_t;

endpackage

// ===== design/bpts_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies beyond bpts_pkg defaults
module bpts_ram #(
    parameter int WIDTH = bpts_pkg::TASK_SLOTS_DEF,
    parameter int DEPTH = bpts_pkg::WAIT_QUEUES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bitmap_priority_task_scheduler.sv =====
// result: registered on commit, once the output is free; a blocked-task stop adds a cancel pass
// beats: a new beat is accepted only in idle, not before the last one is done with the
// read-modify-write of the slot and wait-queue rams (registered read)
// reset: async active low, clears fsm, ready bitmap, current task and ram valid bits;
// no clearing pass, entries without a valid bit read as free or empty
// depends on bpts_pkg, bpts_ram and bitmap_priority_task_scheduler_assert.svh
`include "bitmap_priority_task_scheduler_assert.svh"

module bitmap_priority_task_scheduler #(
    parameter int TASK_SLOTS  = bpts_pkg::TASK_SLOTS_DEF,
    parameter int WAIT_QUEUES = bpts_pkg::WAIT_QUEUES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // action[2:0], task_slot[7:3], wait_queue[10:8], zero fill
    input  logic [bpts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[1:0], chosen_slot[6:2], slot_state[8:7], cancel_notice[9], zero fill
    output logic [bpts_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int QW = (WAIT_QUEUES > 1) ? $clog2(WAIT_QUEUES) : 1;
    localparam int EW = QW + 2;
    localparam int PAD_W = bpts_pkg::OUT_TDATA_W - $bits(bpts_pkg::result_t);

    bpts_pkg::fsm_t    state_reg, state_next;
    bpts_pkg::cmd_t    cmd_reg;
    bpts_pkg::result_t res_reg, res_next;
    logic                  out_valid_reg;
    logic [TASK_SLOTS-1:0] ready_reg, ready_next;
    logic [SW-1:0]         run_slot_reg, run_slot_next;
    logic                  run_vld_reg, run_vld_next;
    logic [TASK_SLOTS-1:0] slot_vld_reg;
    logic [WAIT_QUEUES-1:0] q_vld_reg;
    logic [SW-1:0]         sraddr_reg;
    logic [QW-1:0]         qraddr_reg;

    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic                  go_cancel;

    logic                  slot_rd_en, slot_wr_en;
    logic [SW-1:0]         slot_rd_addr, slot_wr_addr;
    logic [EW-1:0]         slot_rd_data, slot_wr_data;
    logic                  q_rd_en, q_wr_en;
    logic [QW-1:0]         q_rd_addr, q_wr_addr;
    logic [TASK_SLOTS-1:0] q_rd_data, q_wr_data;

    logic                  slot_ok, queue_ok, sraddr_ok, qraddr_ok;
    bpts_pkg::slot_state_t cur_state;
    logic [QW-1:0]         ent_queue;
    logic [TASK_SLOTS-1:0] q_row;
    logic [TASK_SLOTS-1:0] sel_bit, wq_bit;
    logic                  rdy_any, wq_any;
    logic [SW-1:0]         rdy_top, wq_top;

    bpts_ram #(
        .WIDTH (EW),
        .DEPTH (TASK_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    bpts_ram #(
        .WIDTH (TASK_SLOTS),
        .DEPTH (WAIT_QUEUES)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data)
    );

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign commit   = ((state_reg == bpts_pkg::FSM_EXEC) && !go_cancel && out_free)
                   || ((state_reg == bpts_pkg::FSM_CANCEL) && out_free);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpts_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = bpts_pkg::FSM_EXEC;
                end
            end
            bpts_pkg::FSM_EXEC:
            begin
                if (go_cancel)
                begin
                    state_next = bpts_pkg::FSM_CANCEL;
                end
                else if (commit)
                begin
                    state_next = bpts_pkg::FSM_IDLE;
                end
            end
            bpts_pkg::FSM_CANCEL:
            begin
                if (commit)
                begin
                    state_next = bpts_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = bpts_pkg::FSM_IDLE;
            end
        endcase
    end

    // handshake and ram reads
    always_comb
    begin
        s_axis_tready = 1'b0;
        slot_rd_en    = 1'b0;
        q_rd_en       = 1'b0;
        slot_rd_addr  = SW'(s_axis_tdata[7:3]);
        q_rd_addr     = QW'(s_axis_tdata[10:8]);
        case (state_reg)
            bpts_pkg::FSM_IDLE:
            begin
                s_axis_tready = 1'b1;
                slot_rd_en    = s_axis_tvalid;
                q_rd_en       = s_axis_tvalid;
                if (bpts_pkg::action_t'(s_axis_tdata[2:0]) == bpts_pkg::ACT_BLOCK)
                begin
                    slot_rd_addr = run_slot_reg;
                end
            end
            bpts_pkg::FSM_EXEC:
            begin
                q_rd_en   = go_cancel;
                q_rd_addr = ent_queue;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // read data with valid bits
    assign slot_ok   = int'(cmd_reg.task_slot) < TASK_SLOTS;
    assign queue_ok  = int'(cmd_reg.wait_queue) < WAIT_QUEUES;
    assign sraddr_ok = int'(sraddr_reg) < TASK_SLOTS;
    assign qraddr_ok = int'(qraddr_reg) < WAIT_QUEUES;
    assign cur_state = (sraddr_ok && slot_vld_reg[sraddr_reg])
                     ? bpts_pkg::slot_state_t'(slot_rd_data[1:0]) : bpts_pkg::SS_FREE;
    assign ent_queue = slot_rd_data[EW-1:2];
    assign q_row     = (qraddr_ok && q_vld_reg[qraddr_reg]) ? q_rd_data : '0;
    assign sel_bit   = {{(TASK_SLOTS-1){1'b0}}, 1'b1} << sraddr_reg;
    assign wq_bit    = {{(TASK_SLOTS-1){1'b0}}, 1'b1} << wq_top;

    // highest set bit encoders
    always_comb
    begin
        rdy_any = 1'b0;
        rdy_top = '0;
        wq_any  = 1'b0;
        wq_top  = '0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            if (ready_reg[i])
            begin
                rdy_any = 1'b1;
                rdy_top = SW'(i);
            end
            if (q_row[i])
            begin
                wq_any = 1'b1;
                wq_top = SW'(i);
            end
        end
    end

    // action execution
    always_comb
    begin
        ready_next     = ready_reg;
        run_slot_next  = run_slot_reg;
        run_vld_next   = run_vld_reg;
        go_cancel      = 1'b0;
        slot_wr_en     = 1'b0;
        slot_wr_addr   = sraddr_reg;
        slot_wr_data   = {ent_queue, bpts_pkg::SS_FREE};
        q_wr_en        = 1'b0;
        q_wr_addr      = qraddr_reg;
        q_wr_data      = q_row;
        res_next.status        = bpts_pkg::STS_OK;
        res_next.chosen_slot   = cmd_reg.task_slot;
        res_next.slot_state    = slot_ok ? cur_state : bpts_pkg::SS_FREE;
        res_next.cancel_notice = 1'b0;
        case (cmd_reg.action)
            bpts_pkg::ACT_CREATE:
            begin
                if (slot_ok && cur_state == bpts_pkg::SS_FREE)
                begin
                    slot_wr_en          = commit;
                    slot_wr_data        = {ent_queue, bpts_pkg::SS_DORMANT};
                    res_next.slot_state = bpts_pkg::SS_DORMANT;
                end
                else
                begin
                    res_next.status = bpts_pkg::STS_WRONG;
                end
            end
            bpts_pkg::ACT_DELETE:
            begin
                if (slot_ok && cur_state == bpts_pkg::SS_DORMANT)
                begin
                    slot_wr_en          = commit;
                    slot_wr_data        = {ent_queue, bpts_pkg::SS_FREE};
                    res_next.slot_state = bpts_pkg::SS_FREE;
                end
                else
                begin
                    res_next.status = bpts_pkg::STS_WRONG;
                end
            end
            bpts_pkg::ACT_START:
            begin
                if (slot_ok && cur_state == bpts_pkg::SS_DORMANT)
                begin
                    slot_wr_en          = commit;
                    slot_wr_data        = {ent_queue, bpts_pkg::SS_READY};
                    ready_next          = ready_reg | sel_bit;
                    res_next.slot_state = bpts_pkg::SS_READY;
                end
                else
                begin
                    res_next.status = bpts_pkg::STS_WRONG;
                end
            end
            bpts_pkg::ACT_STOP:
            begin
                if (slot_ok && cur_state == bpts_pkg::SS_READY)
                begin
                    slot_wr_en          = commit;
                    slot_wr_data        = {ent_queue, bpts_pkg::SS_DORMANT};
                    ready_next          = ready_reg & ~sel_bit;
                    res_next.slot_state = bpts_pkg::SS_DORMANT;
                    if (run_vld_reg && run_slot_reg == sraddr_reg)
                    begin
                        run_vld_next = 1'b0;
                    end
                end
                else if (slot_ok && cur_state == bpts_pkg::SS_BLOCKED)
                begin
                    if (state_reg == bpts_pkg::FSM_CANCEL)
                    begin
                        // second pass: queue row of the blocked slot is now read
                        slot_wr_en             = commit;
                        slot_wr_data           = {ent_queue, bpts_pkg::SS_DORMANT};
                        q_wr_en                = commit;
                        q_wr_data              = q_row & ~sel_bit;
                        res_next.slot_state    = bpts_pkg::SS_DORMANT;
                        res_next.cancel_notice = 1'b1;
                        if (run_vld_reg && run_slot_reg == sraddr_reg)
                        begin
                            run_vld_next = 1'b0;
                        end
                    end
                    else
                    begin
                        go_cancel = (state_reg == bpts_pkg::FSM_EXEC);
                    end
                end
                else
                begin
                    res_next.status = bpts_pkg::STS_WRONG;
                end
            end
            bpts_pkg::ACT_PICK:
            begin
                if (rdy_any)
                begin
                    run_slot_next        = rdy_top;
                    run_vld_next         = 1'b1;
                    res_next.chosen_slot = bpts_pkg::SLOT_FIELD_W'(rdy_top);
                    res_next.slot_state  = bpts_pkg::SS_READY;
                end
                else
                begin
                    run_vld_next         = 1'b0;
                    res_next.status      = bpts_pkg::STS_EMPTY;
                    res_next.chosen_slot = '0;
                    res_next.slot_state  = bpts_pkg::SS_FREE;
                end
            end
            bpts_pkg::ACT_BLOCK:
            begin
                res_next.chosen_slot = bpts_pkg::SLOT_FIELD_W'(run_slot_reg);
                res_next.slot_state  = cur_state;
                if (run_vld_reg && queue_ok && cur_state == bpts_pkg::SS_READY)
                begin
                    slot_wr_en          = commit;
                    slot_wr_data        = {qraddr_reg, bpts_pkg::SS_BLOCKED};
                    q_wr_en             = commit;
                    q_wr_data           = q_row | sel_bit;
                    ready_next          = ready_reg & ~sel_bit;
                    run_vld_next        = 1'b0;
                    res_next.slot_state = bpts_pkg::SS_BLOCKED;
                end
                else
                begin
                    res_next.status = bpts_pkg::STS_WRONG;
                end
            end
            bpts_pkg::ACT_WAKE:
            begin
                if (queue_ok && wq_any)
                begin
                    slot_wr_en           = commit;
                    slot_wr_addr         = wq_top;
                    slot_wr_data         = {qraddr_reg, bpts_pkg::SS_READY};
                    q_wr_en              = commit;
                    q_wr_data            = q_row & ~wq_bit;
                    ready_next           = ready_reg | wq_bit;
                    res_next.chosen_slot = bpts_pkg::SLOT_FIELD_W'(wq_top);
                    res_next.slot_state  = bpts_pkg::SS_READY;
                end
                else
                begin
                    res_next.status      = bpts_pkg::STS_EMPTY;
                    res_next.chosen_slot = '0;
                    res_next.slot_state  = bpts_pkg::SS_FREE;
                end
            end
            bpts_pkg::ACT_READ:
            begin
                if (!slot_ok)
                begin
                    res_next.status = bpts_pkg::STS_WRONG;
                end
            end
            default:
            begin
                res_next.status = bpts_pkg::STS_WRONG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpts_pkg::FSM_IDLE;
            out_valid_reg <= 1'b0;
            ready_reg     <= '0;
            run_slot_reg  <= '0;
            run_vld_reg   <= 1'b0;
            slot_vld_reg  <= '0;
            q_vld_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                ready_reg     <= ready_next;
                run_slot_reg  <= run_slot_next;
                run_vld_reg   <= run_vld_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (slot_wr_en)
            begin
                slot_vld_reg[slot_wr_addr] <= 1'b1;
            end
            if (q_wr_en)
            begin
                q_vld_reg[q_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.action     <= bpts_pkg::action_t'(s_axis_tdata[2:0]);
            cmd_reg.task_slot  <= s_axis_tdata[7:3];
            cmd_reg.wait_queue <= s_axis_tdata[10:8];
        end
        if (slot_rd_en)
        begin
            sraddr_reg <= slot_rd_addr;
        end
        if (q_rd_en)
        begin
            qraddr_reg <= q_rd_addr;
        end
        if (commit)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, res_reg};

    `BPTS_ASSERT_NEXT(a_accept_exec, accept, state_reg == bpts_pkg::FSM_EXEC, "accepted beat did not start execution")
    `BPTS_ASSERT_SAME(a_cancel_ok, out_valid_reg && res_reg.cancel_notice, res_reg.status == bpts_pkg::STS_OK, "cancel notice with error status")
    `BPTS_ASSERT_SAME(a_empty_zero, out_valid_reg && res_reg.status == bpts_pkg::STS_EMPTY, res_reg.chosen_slot == 5'd0 && res_reg.slot_state == bpts_pkg::SS_FREE, "empty result carries a slot")
    `BPTS_ASSERT_SAME(a_cancel_entry, state_reg == bpts_pkg::FSM_CANCEL, $past(state_reg) == bpts_pkg::FSM_EXEC || $past(state_reg) == bpts_pkg::FSM_CANCEL, "cancel pass without execution")

endmodule
